@@ hdl/slac_pkg.sv @@
// Shared types and constants for the two-level cache lookup.
`timescale 1ns / 1ps
package slac_pkg;
	localparam int L1_ENTRIES = 1024;
	localparam int L2_ENTRIES = 16384;
	localparam int MAX_WAYS   = 16;
	localparam int ADDR_BITS  = 32;
	localparam int MAX_WAY_BITS = $clog2(MAX_WAYS);
	localparam int L1_AW = $clog2(L1_ENTRIES);
	localparam int L2_AW = $clog2(L2_ENTRIES);
	localparam int TAG_W = 32;
	localparam int SET_W = 15;
	localparam int SLOT_W = SET_W + 4;
	localparam int LINE_W = TAG_W + 1;

	localparam logic [15:0] LFSR_TAPS  = 16'hB400;
	localparam logic [15:0] SEED_RESET = 16'd44257;

	localparam logic [2:0] REG_LEVELS    = 3'd0;
	localparam logic [2:0] REG_L1_BSHIFT = 3'd1;
	localparam logic [2:0] REG_L1_SETS   = 3'd2;
	localparam logic [2:0] REG_L1_WAYS   = 3'd3;
	localparam logic [2:0] REG_L2_BSHIFT = 3'd4;
	localparam logic [2:0] REG_L2_SETS   = 3'd5;
	localparam logic [2:0] REG_L2_WAYS   = 3'd6;
	localparam logic [2:0] REG_SEED      = 3'd7;

	typedef enum logic [1:0] {
		OUT_L1_HIT = 2'd0,
		OUT_L2_HIT = 2'd1,
		OUT_MISS   = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_CHK
	} state_t;
endpackage

@@ hdl/slac_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module slac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

@@ hdl/two_level_set_assoc_cache_lookup.sv @@
// Top level: two-level set-associative cache lookup with random replacement.
//
//  channel | handshake        | word
//  --------+------------------+--------------------------------------------
//  request | start / busy     | address
//  result  | done (strobe)    | outcome, l1_way, l2_way, evictions, counters
//  config  | cfg_we           | cfg_index, cfg_data
//
// Each way probed takes a RAM read (ST_RD), then a compare (ST_CHK); busy
// stays high from accept to done, and busy drops with done. After reset a
// clearing pass writes every line invalid over L2_ENTRIES (16384) addresses
// with busy high. done lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
module two_level_set_assoc_cache_lookup
	import slac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] address,
	output logic        done,
	output logic [1:0]  outcome,
	output logic [3:0]  l1_way,
	output logic [3:0]  l2_way,
	output logic        l1_evicted,
	output logic        l2_evicted,
	output logic [31:0] l1_hit_count,
	output logic [31:0] l1_miss_count,
	output logic [31:0] l2_hit_count,
	output logic [31:0] l2_miss_count,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	state_t state_q, state_d;

	logic [1:0]  levels_q;
	logic [3:0]  l1_bs_q, l1_sb_q, l2_bs_q, l2_sb_q;
	logic [2:0]  l1_wb_q, l2_wb_q;
	logic [15:0] lfsr_q;

	logic [ADDR_BITS-1:0] addr_q;
	logic        lvl_q;
	logic [3:0]  way_q;
	logic [L2_AW-1:0] clr_q;
	logic        done_q;
	logic [1:0]  outcome_q;
	logic [3:0]  l1_way_q, l2_way_q;
	logic        l1_ev_q, l2_ev_q;
	logic [31:0] cnt_q [4];

	logic [3:0]  bs_c, sb_c;
	logic [2:0]  wb_raw_c, wb_c;
	logic [3:0]  ways_m1_c;
	logic [31:0] blk_c, tag_c;
	logic [SET_W-1:0] set_c;
	logic [LINE_W-1:0] l1_rdata, l2_rdata, rd_c;
	logic        hit_c, empty_c, last_c, full_c, resolve_c, fill_c;
	logic [3:0]  fill_way_c;
	logic [SLOT_W-1:0] probe_slot_c, fill_slot_c;
	logic        l1_we, l2_we;
	logic [L1_AW-1:0] l1_addr;
	logic [L2_AW-1:0] l2_addr;
	logic [LINE_W-1:0] wdata_c;
	logic        go_l2_c;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [SET_W-1:0] set,
			input logic [2:0] wb, input logic [3:0] w);
		return (SLOT_W'(set) << wb) | SLOT_W'(w);
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// level geometry
	always_comb begin
		bs_c     = lvl_q ? l2_bs_q : l1_bs_q;
		sb_c     = lvl_q ? l2_sb_q : l1_sb_q;
		wb_raw_c = lvl_q ? l2_wb_q : l1_wb_q;
		wb_c     = (wb_raw_c > 3'(MAX_WAY_BITS)) ? 3'(MAX_WAY_BITS) : wb_raw_c;
		ways_m1_c = 4'((5'd1 << wb_c) - 5'd1);
		blk_c    = addr_q >> bs_c;
		set_c    = SET_W'(blk_c) & SET_W'((16'd1 << sb_c) - 16'd1);
		tag_c    = blk_c >> sb_c;
	end

	// way compare
	always_comb begin
		rd_c       = lvl_q ? l2_rdata : l1_rdata;
		empty_c    = !rd_c[LINE_W-1];
		hit_c      = rd_c[LINE_W-1] && (rd_c[TAG_W-1:0] == tag_c);
		last_c     = (way_q == ways_m1_c);
		resolve_c  = (state_q == ST_CHK) && (hit_c || empty_c || last_c);
		full_c     = !hit_c && !empty_c && last_c;
		fill_c     = resolve_c && !hit_c;
		fill_way_c = full_c ? (lfsr_q[3:0] & ways_m1_c) : way_q;
		probe_slot_c = slot_of(set_c, wb_c, way_q);
		fill_slot_c  = slot_of(set_c, wb_c, fill_way_c);
		go_l2_c    = !lvl_q && !hit_c && levels_q[1];
		wdata_c    = {1'b1, tag_c};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == L2_AW'(L2_ENTRIES - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_RD;
			ST_RD:    state_d = ST_CHK;
			ST_CHK: begin
				if (!resolve_c || go_l2_c) state_d = ST_RD;
				else state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		l1_we = 1'b0;
		l2_we = 1'b0;
		l1_addr = L1_AW'(probe_slot_c);
		l2_addr = L2_AW'(probe_slot_c);
		case (state_q)
			ST_CLEAR: begin
				l1_we = 1'b1;
				l2_we = 1'b1;
				l1_addr = clr_q[L1_AW-1:0];
				l2_addr = clr_q;
			end
			ST_CHK: begin
				if (fill_c) begin
					l1_we = !lvl_q;
					l2_we = lvl_q;
					l1_addr = L1_AW'(fill_slot_c);
					l2_addr = L2_AW'(fill_slot_c);
				end
			end
			default: ;
		endcase
	end

	slac_ram #(.WIDTH(LINE_W), .DEPTH(L1_ENTRIES)) u_l1_ram (
		.clk   (clk),
		.we    (l1_we),
		.addr  (l1_addr),
		.wdata (state_q == ST_CLEAR ? '0 : wdata_c),
		.rdata (l1_rdata)
	);

	slac_ram #(.WIDTH(LINE_W), .DEPTH(L2_ENTRIES)) u_l2_ram (
		.clk   (clk),
		.we    (l2_we),
		.addr  (l2_addr),
		.wdata (state_q == ST_CLEAR ? '0 : wdata_c),
		.rdata (l2_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			levels_q <= 2'd2;
			l1_bs_q  <= 4'd6;
			l1_sb_q  <= 4'd9;
			l1_wb_q  <= 3'd1;
			l2_bs_q  <= 4'd6;
			l2_sb_q  <= 4'd11;
			l2_wb_q  <= 3'd3;
			lfsr_q   <= SEED_RESET;
			done_q   <= 1'b0;
			lvl_q    <= 1'b0;
			way_q    <= '0;
			for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;

			if (cfg_we) begin
				case (cfg_index)
					REG_LEVELS:    levels_q <= cfg_data[1:0];
					REG_L1_BSHIFT: l1_bs_q  <= cfg_data[3:0];
					REG_L1_SETS:   l1_sb_q  <= cfg_data[3:0];
					REG_L1_WAYS:   l1_wb_q  <= cfg_data[2:0];
					REG_L2_BSHIFT: l2_bs_q  <= cfg_data[3:0];
					REG_L2_SETS:   l2_sb_q  <= cfg_data[3:0];
					REG_L2_WAYS:   l2_wb_q  <= cfg_data[2:0];
					REG_SEED:      lfsr_q   <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
					default: ;
				endcase
			end

			if (state_q == ST_IDLE && start) begin
				lvl_q <= 1'b0;
				way_q <= '0;
			end else if (state_q == ST_CHK) begin
				if (!resolve_c) begin
					way_q <= way_q + 4'd1;
				end else begin
					// random pick only when a full set with several ways is replaced
					if (full_c && wb_c != 3'd0)
						lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 16'd0);
					if (!lvl_q) begin
						if (hit_c) cnt_q[0] <= sat_inc(cnt_q[0]);
						else cnt_q[1] <= sat_inc(cnt_q[1]);
					end else begin
						if (hit_c) cnt_q[2] <= sat_inc(cnt_q[2]);
						else cnt_q[3] <= sat_inc(cnt_q[3]);
					end
					if (go_l2_c) begin
						lvl_q <= 1'b1;
						way_q <= '0;
					end else begin
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			addr_q   <= address;
			l2_way_q <= '0;
			l2_ev_q  <= 1'b0;
		end else if (resolve_c) begin
			if (!lvl_q) begin
				l1_way_q  <= fill_way_c;
				l1_ev_q   <= full_c;
				outcome_q <= hit_c ? OUT_L1_HIT : OUT_MISS;
			end else begin
				l2_way_q  <= fill_way_c;
				l2_ev_q   <= full_c;
				outcome_q <= hit_c ? OUT_L2_HIT : OUT_MISS;
			end
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign outcome       = outcome_q;
	assign l1_way        = l1_way_q;
	assign l2_way        = l2_way_q;
	assign l1_evicted    = l1_ev_q;
	assign l2_evicted    = l2_ev_q;
	assign l1_hit_count  = cnt_q[0];
	assign l1_miss_count = cnt_q[1];
	assign l2_hit_count  = cnt_q[2];
	assign l2_miss_count = cnt_q[3];
endmodule

@@ hdl/slac_checker.sv @@
// Port-level checks for the cache lookup, bound to the top level.
`timescale 1ns / 1ps
module slac_checker
	import slac_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] outcome,
	input logic [3:0] l2_way,
	input logic       l2_evicted
);
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (outcome == OUT_L1_HIT || outcome == OUT_L2_HIT || outcome == OUT_MISS))
		else $error("bad outcome code");

	a_l1_hit_l2_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome == OUT_L1_HIT |-> l2_way == 4'd0 && !l2_evicted)
		else $error("level two fields set on level one hit");
endmodule

bind two_level_set_assoc_cache_lookup slac_checker u_slac_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.outcome    (outcome),
	.l2_way     (l2_way),
	.l2_evicted (l2_evicted)
);

@@ bench/two_level_set_assoc_cache_lookup_tb.sv @@
// Self-checking bench for the two-level set-associative cache lookup.
`timescale 1ns / 1ps
module two_level_set_assoc_cache_lookup_tb;
	import slac_pkg::*;

	typedef struct {
		outcome_t    outcome;
		logic [3:0]  l1_way;
		logic [3:0]  l2_way;
		logic        l1_ev;
		logic        l2_ev;
		logic [31:0] cnt [4];
	} lookup_word_t;

	typedef struct {
		logic [3:0] way;
		logic       hit;
		logic       ev;
	} probe_res_t;

	class lookup_scoreboard;
		logic [1:0]  levels;
		logic [3:0]  bshift [2];
		logic [3:0]  sbits [2];
		logic [2:0]  wbits [2];
		logic [15:0] lfsr;
		logic [31:0] l1_tag [L1_ENTRIES];
		bit          l1_vld [L1_ENTRIES];
		logic [31:0] l2_tag [L2_ENTRIES];
		bit          l2_vld [L2_ENTRIES];
		logic [31:0] cnt [4];
		lookup_word_t pending [$];
		int errors;

		function new();
			levels = 2;
			bshift[0] = 6; sbits[0] = 9; wbits[0] = 1;
			bshift[1] = 6; sbits[1] = 11; wbits[1] = 3;
			lfsr = SEED_RESET;
			foreach (l1_vld[i]) l1_vld[i] = 0;
			foreach (l2_vld[i]) l2_vld[i] = 0;
			foreach (cnt[i]) cnt[i] = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] d);
			case (idx)
				REG_LEVELS:    levels = d[1:0];
				REG_L1_BSHIFT: bshift[0] = d[3:0];
				REG_L1_SETS:   sbits[0] = d[3:0];
				REG_L1_WAYS:   wbits[0] = d[2:0];
				REG_L2_BSHIFT: bshift[1] = d[3:0];
				REG_L2_SETS:   sbits[1] = d[3:0];
				REG_L2_WAYS:   wbits[1] = d[2:0];
				REG_SEED:      lfsr = (d == 0) ? 16'd1 : d;
				default: ;
			endcase
		endfunction

		function void bump(int i);
			if (cnt[i] != 32'hFFFF_FFFF) cnt[i]++;
		endfunction

		function probe_res_t probe(int lv, logic [31:0] addr);
			probe_res_t r;
			logic [31:0] blk, tag, set;
			int wb, ways, w, slot, n;
			bit v;
			blk = addr >> bshift[lv];
			set = blk & ((32'd1 << sbits[lv]) - 1);
			tag = blk >> sbits[lv];
			wb = wbits[lv];
			while (wb > 0 && (1 << wb) > MAX_WAYS) wb--;
			ways = 1 << wb;
			n = lv ? L2_ENTRIES : L1_ENTRIES;
			r.hit = 0; r.ev = 0; slot = 0;
			for (w = 0; w < ways; w++) begin
				slot = (set * ways + w) % n;
				v = lv ? l2_vld[slot] : l1_vld[slot];
				if (!v) break;
				if ((lv ? l2_tag[slot] : l1_tag[slot]) == tag) begin
					r.hit = 1;
					break;
				end
			end
			if (!r.hit) begin
				if (w == ways) begin
					if (ways > 1) begin
						w = lfsr & (ways - 1);
						lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
					end else w = 0;
					slot = (set * ways + w) % n;
					r.ev = 1;
				end
				if (lv) begin
					l2_tag[slot] = tag; l2_vld[slot] = 1;
				end else begin
					l1_tag[slot] = tag; l1_vld[slot] = 1;
				end
			end
			r.way = w;
			return r;
		endfunction

		function void note_address(logic [31:0] addr);
			lookup_word_t e;
			probe_res_t p1, p2;
			p1 = probe(0, addr);
			e.l1_way = p1.way; e.l1_ev = p1.ev; e.l2_way = 0; e.l2_ev = 0;
			if (p1.hit) begin
				bump(0); e.outcome = OUT_L1_HIT;
			end else begin
				bump(1); e.outcome = OUT_MISS;
				if (levels >= 2) begin
					p2 = probe(1, addr);
					e.l2_way = p2.way; e.l2_ev = p2.ev;
					if (p2.hit) begin
						bump(2); e.outcome = OUT_L2_HIT;
					end else bump(3);
				end
			end
			e.cnt = cnt;
			pending.push_back(e);
		endfunction

		function void check_result(lookup_word_t a);
			lookup_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result outcome=%0d", $time, a.outcome);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.outcome !== e.outcome || a.l1_way !== e.l1_way || a.l2_way !== e.l2_way ||
			    a.l1_ev !== e.l1_ev || a.l2_ev !== e.l2_ev || a.cnt != e.cnt) begin
				$display("%0t: mismatch exp out=%0d w1=%0d w2=%0d ev=%b%b cnt=%h %h %h %h",
					$time, e.outcome, e.l1_way, e.l2_way, e.l1_ev, e.l2_ev,
					e.cnt[0], e.cnt[1], e.cnt[2], e.cnt[3]);
				$display("%0t:          got out=%0d w1=%0d w2=%0d ev=%b%b cnt=%h %h %h %h",
					$time, a.outcome, a.l1_way, a.l2_way, a.l1_ev, a.l2_ev,
					a.cnt[0], a.cnt[1], a.cnt[2], a.cnt[3]);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n, start, cfg_we;
	logic        busy, done, l1_evicted, l2_evicted;
	logic [31:0] address;
	logic [1:0]  outcome;
	logic [3:0]  l1_way, l2_way;
	logic [31:0] l1_hit_count, l1_miss_count, l2_hit_count, l2_miss_count;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	lookup_scoreboard sb;
	int idle_cycles;
	logic [31:0] recent [$];

	two_level_set_assoc_cache_lookup DUT (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// results are strobes; sample at the edge that ends the cycle
	always @(posedge clk) begin
		lookup_word_t a;
		if (arst_n && done) begin
			a.outcome = outcome_t'(outcome);
			a.l1_way = l1_way; a.l2_way = l2_way;
			a.l1_ev = l1_evicted; a.l2_ev = l2_evicted;
			a.cnt[0] = l1_hit_count; a.cnt[1] = l1_miss_count;
			a.cnt[2] = l2_hit_count; a.cnt[3] = l2_miss_count;
			sb.check_result(a);
		end
	end

	// watchdog: fails the run when idle_cycles passes its limit with no accepted start, done or config write
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 40000) begin
			$display("two_level_set_assoc_cache_lookup regression: fail");
			$finish;
		end
	end

	// start drops only when the gap is not empty
	task automatic gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_word(logic [31:0] a, bit idle_ok);
		cfg_we <= 0;
		start <= 1;
		address <= a;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_address(a);
		recent.push_back(a);
		if (recent.size() > 32) void'(recent.pop_front());
		if (idle_ok) gap();
	endtask

	task automatic drain();
		start <= 0;
		cfg_we <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] d);
		start <= 0;
		cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
	endtask

	function automatic logic [31:0] rand_addr();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5 && recent.size() > 0) return recent[$urandom_range(0, recent.size() - 1)];
		if (k < 8) return $urandom_range(0, 16'hFFFF) << $urandom_range(0, 8);
		return $urandom();
	endfunction

	initial begin
		int phase;
		sb = new();
		arst_n = 0; start = 0; address = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset geometry, extremes, repeats for hits
		send_word(32'h0, 0);
		send_word(32'h0, 0);
		send_word(32'hFFFF_FFFF, 0);
		send_word(32'hFFFF_FFFF, 1);
		send_word(32'h8000_0040, 0);
		send_word(32'h5555_5555, 0);
		send_word(32'hAAAA_AAAA, 0);
		drain();
		// one way, one set: every miss evicts
		write_reg(REG_LEVELS, 1);
		write_reg(REG_L1_WAYS, 0);
		write_reg(REG_L1_SETS, 0);
		write_reg(REG_L1_BSHIFT, 0);
		send_word(32'h1, 0); send_word(32'h2, 0); send_word(32'h2, 0);
		drain();
		// out-of-range values: level count 0 and 3, too many ways, zero seed
		write_reg(REG_LEVELS, 0);
		write_reg(REG_L1_WAYS, 7);
		write_reg(REG_SEED, 0);
		for (int i = 0; i < 18; i++) send_word(i << 12, 0);
		drain();
		write_reg(REG_LEVELS, 3);
		write_reg(REG_L2_WAYS, 5);
		write_reg(REG_L2_SETS, 15);
		write_reg(REG_L2_BSHIFT, 15);
		write_reg(REG_L1_SETS, 15);
		write_reg(REG_L1_BSHIFT, 15);
		for (int i = 0; i < 4; i++) send_word($urandom(), 0);
		drain();

		// random phases with changing geometry; stale lines are kept
		for (phase = 0; phase < 10; phase++) begin
			write_reg(REG_LEVELS, $urandom_range(0, 3));
			write_reg(REG_L1_BSHIFT, (phase == 1) ? 12 : $urandom_range(0, 12));
			write_reg(REG_L1_SETS, (phase == 1) ? 10 : $urandom_range(0, 4));
			write_reg(REG_L1_WAYS, (phase == 2) ? 4 : $urandom_range(0, 4));
			write_reg(REG_L2_BSHIFT, (phase == 1) ? 0 : $urandom_range(0, 12));
			write_reg(REG_L2_SETS, (phase == 1) ? 14 : $urandom_range(0, 6));
			write_reg(REG_L2_WAYS, (phase == 3) ? 4 : $urandom_range(0, 4));
			write_reg(REG_SEED, (phase == 4) ? 16'hFFFF : $urandom_range(1, 16'hFFFF));
			for (int i = 0; i < 62; i++) begin
				send_word(rand_addr(), $urandom_range(0, 3) != 0);
				if (i == 30 && phase == 5) drain();
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("two_level_set_assoc_cache_lookup regression: pass");
		else
			$display("two_level_set_assoc_cache_lookup regression: fail");
		$finish;
	end
endmodule

@@ sim.f @@
hdl/slac_pkg.sv
hdl/slac_ram.sv
hdl/two_level_set_assoc_cache_lookup.sv
hdl/slac_checker.sv
bench/two_level_set_assoc_cache_lookup_tb.sv
